// ----- rtl/mp2_pkg.sv -----
`default_nettype none
package mp2_pkg;

   // csr register indexes
   localparam logic [1:0] REG_PLANE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_PLANE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_STRIDE_MODE  = 2'd2;

   localparam logic [9:0]  RESET_PLANE_WIDTH  = 10'd416;
   localparam logic [10:0] RESET_PLANE_HEIGHT = 11'd416;

   localparam int MAX_HEIGHT  = 1024;
   localparam int QUEUE_DEPTH = 4;

   // result slots of one job, in output order
   localparam logic [1:0] SLOT_WINDOW = 2'd0;  // full 2x2 window
   localparam logic [1:0] SLOT_RIGHT  = 2'd1;  // right border, row above
   localparam logic [1:0] SLOT_BELOW  = 2'd2;  // bottom border, left column
   localparam logic [1:0] SLOT_CORNER = 2'd3;  // bottom-right corner

   typedef struct packed {
      logic [9:0]  plane_width;
      logic [10:0] plane_height;
      logic        stride_mode;
   } cfg_type;

   typedef struct packed {
      logic [9:0] row;
      logic [9:0] col;
      logic [3:0] mask;     // slots that produce a result
      logic       mode;
      logic       eop_window;
   } job_ctrl_type;

endpackage
`default_nettype wire

// ----- rtl/max_pool_2x2_stream.sv -----
// 2x2 max pooling over one channel plane, pixels in raster order.
// req_*  : one pixel per request, tdata[DATA_BITS-1:0] two's complement.
// rsp_*  : pooled results, pooled_value, out_row, out_col in tdata from
//          the low bit up; tlast marks the final result of one pixel,
//          tuser marks the final result of the plane.
// csr_*  : write-only registers (width, height, stride mode), to be
//          written only while the block is idle; the block does not enforce it.
// Stride 2 gives one result per odd row/odd column; stride 1 gives one
// result per pixel with zero padding on the right and bottom edges; row 0
// and column 0 give none, later row-end and bottom-row pixels two, the last
// pixel of a plane four.
// Throughput: one request per cycle while each pixel yields at most one
// result; the result register emits one result per cycle, and a 4-entry
// job queue absorbs the row-end bursts before req_tready drops.
// The line store is a single RAM, read and written once per request.
// Reset (synchronous) clears position, queue and output state and loads
// the register defaults 416 x 416, stride 2; no clearing pass is needed.
// A stalled rsp_tready holds the result register; requests keep flowing
// until the job queue is full.
`default_nettype none
module max_pool_2x2_stream #(
   parameter int MAX_WIDTH = 512,
   parameter int DATA_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // request channel
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   input  wire logic [((DATA_BITS+7)/8)*8-1:0]          req_tdata,  // pixel_value
   // result channel
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   output logic [((DATA_BITS+19+7)/8)*8-1:0]            rsp_tdata,  // pooled_value, out_row, out_col
   output logic                                         rsp_tlast,  // last_of_run
   output logic                                         rsp_tuser,  // end_of_plane
   // register writes
   input  wire logic                                    csr_we,
   input  wire logic [1:0]                              csr_addr,
   input  wire logic [10:0]                             csr_wdata
);

   localparam int CTRLW  = $bits(mp2_pkg::job_ctrl_type);
   localparam int JOBW   = CTRLW + 4 * DATA_BITS;
   localparam int QCW    = $clog2(mp2_pkg::QUEUE_DEPTH + 1);

   logic [9:0]  plane_width_ff;
   logic [10:0] plane_height_ff;
   logic        stride_mode_ff;
   mp2_pkg::cfg_type cfg;

   logic                  push, pop, q_empty;
   logic [QCW-1:0]        q_count;
   mp2_pkg::job_ctrl_type push_ctrl, head_ctrl;
   logic [4*DATA_BITS-1:0] push_vals;
   logic [JOBW-1:0]       head_job;

   logic [DATA_BITS-1:0]  pooled_value;
   logic [9:0]            out_row;
   logic [8:0]            out_col;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_width_ff  <= mp2_pkg::RESET_PLANE_WIDTH;
         plane_height_ff <= mp2_pkg::RESET_PLANE_HEIGHT;
         stride_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            mp2_pkg::REG_PLANE_WIDTH:  plane_width_ff  <= csr_wdata[9:0];
            mp2_pkg::REG_PLANE_HEIGHT: plane_height_ff <= csr_wdata;
            mp2_pkg::REG_STRIDE_MODE:  stride_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.plane_width  = plane_width_ff;
   assign cfg.plane_height = plane_height_ff;
   assign cfg.stride_mode  = stride_mode_ff;

   // front: position tracking, line store, window maxima
   mp2_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .DATA_BITS (DATA_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .pixel_value (req_tdata[DATA_BITS-1:0]),
      .queue_count (q_count),
      .push        (push),
      .push_ctrl   (push_ctrl),
      .push_vals   (push_vals)
   );

   // jobs waiting for the result sequencer
   mp2_queue #(
      .WIDTH (JOBW),
      .DEPTH (mp2_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_vals, push_ctrl}),
      .pop       (pop),
      .pop_data  (head_job),
      .empty     (q_empty),
      .count     (q_count)
   );

   assign head_ctrl = head_job[CTRLW-1:0];

   // back: one result per cycle into the output register while rsp_tready is high
   mp2_back #(
      .DATA_BITS (DATA_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (!q_empty),
      .head_ctrl    (head_ctrl),
      .head_vals    (head_job[JOBW-1:CTRLW]),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .pooled_value (pooled_value),
      .out_row      (out_row),
      .out_col      (out_col),
      .last_of_run  (rsp_tlast),
      .end_of_plane (rsp_tuser)
   );

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[DATA_BITS-1:0]              = pooled_value;
      rsp_tdata[DATA_BITS+9:DATA_BITS]      = out_row;
      rsp_tdata[DATA_BITS+18:DATA_BITS+10]  = out_col;
   end

`ifndef NO_ASSERTIONS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (q_count < QCW'(mp2_pkg::QUEUE_DEPTH)))
      else $error("job pushed into a full queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (q_count != '0))
      else $error("job popped from an empty queue");

   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (q_count < QCW'(mp2_pkg::QUEUE_DEPTH)))
      else $error("request taken with no queue room");

   a_eop_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("end of plane without last of run");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && q_empty))
      else $error("output or queue busy after reset");
`endif

endmodule
`default_nettype wire

// ----- rtl/mp2_ram.sv -----
`default_nettype none
module mp2_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-first: a same-address write shows up on the next read only
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- rtl/mp2_queue.sv -----
`default_nettype none
module mp2_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   input  wire logic                       pop,
   output logic      [WIDTH-1:0]           pop_data,
   output logic                            empty,
   output logic      [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule
`default_nettype wire

// ----- rtl/mp2_front.sv -----
`default_nettype none
module mp2_front #(
   parameter int MAX_WIDTH = 512,
   parameter int DATA_BITS = 16
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire mp2_pkg::cfg_type                               cfg,
   input  wire logic                                           req_tvalid,
   output logic                                                req_tready,
   input  wire logic signed [DATA_BITS-1:0]                    pixel_value,
   input  wire logic [$clog2(mp2_pkg::QUEUE_DEPTH+1)-1:0]      queue_count,
   output logic                                                push,
   output mp2_pkg::job_ctrl_type                               push_ctrl,
   output logic [4*DATA_BITS-1:0]                              push_vals
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = ((AW > 10) ? AW : 10) + 2;
   localparam int HW = 12;
   localparam int CW = $clog2(mp2_pkg::QUEUE_DEPTH + 1) + 1;

   function automatic logic signed [DATA_BITS-1:0] smax(
      input logic signed [DATA_BITS-1:0] a,
      input logic signed [DATA_BITS-1:0] b
   );
      return (a > b) ? a : b;
   endfunction

   // position counters
   logic [AW-1:0] col_ff, col_in;
   logic [9:0]    row_ff, row_in;

   logic [WW-1:0] pw, w_eff, c_ext;
   logic [HW-1:0] ph, h_eff, r_ext;
   logic          row_end, last_row, eop_window, accept;

   // join stage, lines up with the line-store read
   logic                        s1_valid_ff;
   logic signed [DATA_BITS-1:0] s1_pix_ff;
   logic [9:0]                  s1_row_ff;
   logic [AW-1:0]               s1_col_ff;
   logic                        s1_row_end_ff, s1_last_row_ff, s1_mode_ff, s1_eop_ff;

   logic signed [DATA_BITS-1:0] left_current_ff, left_above_ff;
   logic signed [DATA_BITS-1:0] above, v0, v1, v2, v3;
   logic [DATA_BITS-1:0]        ram_rdata;
   logic [3:0]                  mask;
   logic                        r_nz, c_nz;
   logic [WW-1:0]               s1_col_ext;

   always_comb begin
      pw    = WW'(cfg.plane_width);
      w_eff = (pw < WW'(2)) ? WW'(2) : ((pw > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : pw);
      ph    = HW'(cfg.plane_height);
      h_eff = (ph < HW'(2)) ? HW'(2)
            : ((ph > HW'(mp2_pkg::MAX_HEIGHT)) ? HW'(mp2_pkg::MAX_HEIGHT) : ph);
      c_ext = WW'(col_ff);
      r_ext = HW'(row_ff);
      row_end    = (c_ext >= w_eff - WW'(1));
      last_row   = (r_ext >= h_eff - HW'(1));
      eop_window = (r_ext + HW'(2) >= h_eff) && (c_ext + WW'(2) >= w_eff);
   end

   // room is held back for the item in the join stage
   assign req_tready = ((CW'(queue_count) + CW'(s1_valid_ff)) < CW'(mp2_pkg::QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   mp2_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock (clock),
      .we    (accept),
      .waddr (col_ff),
      .wdata (pixel_value),
      .re    (accept),
      .raddr (col_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         left_current_ff <= '0;
         left_above_ff   <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         if (s1_valid_ff) begin
            left_current_ff <= s1_pix_ff;
            left_above_ff   <= above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= pixel_value;
         s1_row_ff      <= row_ff;
         s1_col_ff      <= col_ff;
         s1_row_end_ff  <= row_end;
         s1_last_row_ff <= last_row;
         s1_mode_ff     <= cfg.stride_mode;
         s1_eop_ff      <= eop_window;
      end
   end

   always_comb begin
      above = $signed(ram_rdata);
      v0    = smax(smax(left_above_ff, above), smax(left_current_ff, s1_pix_ff));
      v1    = smax(smax(above, s1_pix_ff), '0);
      v2    = smax(smax(left_current_ff, s1_pix_ff), '0);
      v3    = smax(s1_pix_ff, '0);
      r_nz  = (s1_row_ff != '0);
      c_nz  = (s1_col_ff != '0);
      if (s1_mode_ff) begin
         mask = {s1_last_row_ff && s1_row_end_ff, s1_last_row_ff && c_nz,
                 r_nz && s1_row_end_ff, r_nz && c_nz};
      end else begin
         mask = {3'b000, s1_row_ff[0] && s1_col_ff[0]};
      end
      s1_col_ext           = WW'(s1_col_ff);
      push                 = s1_valid_ff && (mask != 4'b0000);
      push_ctrl.row        = s1_row_ff;
      push_ctrl.col        = s1_col_ext[9:0];
      push_ctrl.mask       = mask;
      push_ctrl.mode       = s1_mode_ff;
      push_ctrl.eop_window = s1_eop_ff;
      push_vals            = {v3, v2, v1, v0};
   end

endmodule
`default_nettype wire

// ----- rtl/mp2_back.sv -----
`default_nettype none
module mp2_back #(
   parameter int DATA_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        head_valid,
   input  wire mp2_pkg::job_ctrl_type       head_ctrl,
   input  wire logic [4*DATA_BITS-1:0]      head_vals,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [DATA_BITS-1:0]             pooled_value,
   output logic [9:0]                       out_row,
   output logic [8:0]                       out_col,
   output logic                             last_of_run,
   output logic                             end_of_plane
);

   logic [3:0]           done_ff, done_in;
   logic                 valid_ff, valid_in;
   logic [DATA_BITS-1:0] value_ff;
   logic [9:0]           row_ff, row_sel, row_m1;
   logic [8:0]           col_ff, col_sel;
   logic [9:0]           col_m1;
   logic                 last_ff, eop_ff, eop_sel;
   logic [3:0]           pend, sel_hot, rest;
   logic [1:0]           sel;
   logic                 load;

   always_comb begin
      pend = head_ctrl.mask & ~done_ff;
      if (pend[0]) begin
         sel = mp2_pkg::SLOT_WINDOW;
      end else if (pend[1]) begin
         sel = mp2_pkg::SLOT_RIGHT;
      end else if (pend[2]) begin
         sel = mp2_pkg::SLOT_BELOW;
      end else begin
         sel = mp2_pkg::SLOT_CORNER;
      end
      sel_hot = 4'b0001 << sel;
      rest    = pend & ~sel_hot;

      row_m1 = head_ctrl.row - 10'd1;
      col_m1 = head_ctrl.col - 10'd1;
      case (sel)
         mp2_pkg::SLOT_WINDOW: begin
            row_sel = head_ctrl.mode ? row_m1 : {1'b0, head_ctrl.row[9:1]};
            col_sel = head_ctrl.mode ? col_m1[8:0] : head_ctrl.col[9:1];
            eop_sel = !head_ctrl.mode && head_ctrl.eop_window;
         end
         mp2_pkg::SLOT_RIGHT: begin
            row_sel = row_m1;
            col_sel = head_ctrl.col[8:0];
            eop_sel = 1'b0;
         end
         mp2_pkg::SLOT_BELOW: begin
            row_sel = head_ctrl.row;
            col_sel = col_m1[8:0];
            eop_sel = 1'b0;
         end
         default: begin
            row_sel = head_ctrl.row;
            col_sel = head_ctrl.col[8:0];
            eop_sel = 1'b1;
         end
      endcase

      load     = head_valid && (!valid_ff || rsp_tready);
      pop      = load && (rest == 4'b0000);
      done_in  = done_ff;
      valid_in = valid_ff;
      if (load) begin
         done_in  = pop ? 4'b0000 : (done_ff | sel_hot);
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= head_vals[sel*DATA_BITS +: DATA_BITS];
         row_ff   <= row_sel;
         col_ff   <= col_sel;
         last_ff  <= (rest == 4'b0000);
         eop_ff   <= eop_sel;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign pooled_value = value_ff;
   assign out_row      = row_ff;
   assign out_col      = col_ff;
   assign last_of_run  = last_ff;
   assign end_of_plane = eop_ff;

endmodule
`default_nettype wire
